[rtl/core/hcbp_pkg.sv]
// Shared types and constants for the Huffman code bit packer.
// No dependencies; used by every file in rtl/core.
package hcbp_pkg;

	localparam int SYMBOL_COUNT = 256;
	localparam int MAX_CODE_LEN = 32;
	localparam int BYTE_W       = 8;
	localparam int SYM_W        = 8;
	localparam int CODE_W       = 32;
	localparam int LEN_W        = 6;
	localparam int MODE_W       = 2;
	localparam int ADDR_W       = $clog2(SYMBOL_COUNT);
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int IN_DATA_W    = 48;
	localparam int OUT_DATA_W   = 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD   = 2'd0,
		MODE_ENCODE = 2'd1,
		MODE_FLUSH  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	// Work handed from front to back: a code top-aligned in word, or a flush.
	typedef struct packed {
		logic              flush;
		logic [CODE_W-1:0] word;
		logic [LEN_W-1:0]  len;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} qstat_t;

endpackage

[rtl/core/hcbp_front.sv]
// Front end: input transfer, code table (write on load, registered read on encode),
// alignment of the code to the top of the word. Depends on hcbp_pkg.
module hcbp_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [hcbp_pkg::IN_DATA_W-1:0] s_tdata,  // symbol, code_word, code_length, pad
	input  logic [hcbp_pkg::MODE_W-1:0]  s_tuser,    // mode
	input  logic                         q_full,
	output hcbp_pkg::push_t              push
);

	logic [hcbp_pkg::SYM_W-1:0]  symbol;
	logic [hcbp_pkg::CODE_W-1:0] code_word;
	logic [hcbp_pkg::LEN_W-1:0]  code_length;
	logic [hcbp_pkg::LEN_W-1:0]  len_sat;
	hcbp_pkg::mode_t             mode;
	logic                        accept;
	logic                        in_range;
	logic [hcbp_pkg::ADDR_W-1:0] addr;

	logic [hcbp_pkg::LEN_W+hcbp_pkg::CODE_W-1:0] table_mem [hcbp_pkg::SYMBOL_COUNT];
	logic [hcbp_pkg::LEN_W+hcbp_pkg::CODE_W-1:0] rd_s1;

	logic valid_s1;
	logic flush_s1;
	logic hit_s1;

	logic [hcbp_pkg::CODE_W-1:0] rd_word;
	logic [hcbp_pkg::LEN_W-1:0]  rd_len;
	logic [hcbp_pkg::LEN_W-1:0]  align_sh;

	assign symbol      = s_tdata[hcbp_pkg::SYM_W-1:0];
	assign code_word   = s_tdata[hcbp_pkg::SYM_W+hcbp_pkg::CODE_W-1:hcbp_pkg::SYM_W];
	assign code_length = s_tdata[hcbp_pkg::SYM_W+hcbp_pkg::CODE_W+hcbp_pkg::LEN_W-1:
		hcbp_pkg::SYM_W+hcbp_pkg::CODE_W];
	assign mode        = hcbp_pkg::mode_t'(s_tuser);
	assign accept      = s_tvalid && s_tready;
	assign in_range    = (9'(symbol) < 9'(hcbp_pkg::SYMBOL_COUNT));
	assign addr        = symbol[hcbp_pkg::ADDR_W-1:0];
	assign len_sat     = (code_length > hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN)) ?
		hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN) : code_length;

	// s1 holds one encode or flush until the queue takes it
	assign s_tready = !valid_s1 || !q_full;

	always_ff @(posedge clk) begin
		if (accept && mode == hcbp_pkg::MODE_LOAD && in_range) begin
			table_mem[addr] <= {len_sat, code_word};
		end
		if (accept && mode == hcbp_pkg::MODE_ENCODE) begin
			rd_s1 <= table_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= accept && (mode == hcbp_pkg::MODE_ENCODE || mode == hcbp_pkg::MODE_FLUSH);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flush_s1 <= (mode == hcbp_pkg::MODE_FLUSH);
			hit_s1   <= in_range;
		end
	end

	assign rd_word  = rd_s1[hcbp_pkg::CODE_W-1:0];
	assign rd_len   = (hit_s1 && !flush_s1) ? rd_s1[hcbp_pkg::LEN_W+hcbp_pkg::CODE_W-1:hcbp_pkg::CODE_W]
		: '0;
	assign align_sh = hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W) - rd_len;

	// shifting by the full width leaves zero, which is what a zero-length code needs
	always_comb begin
		push.valid       = valid_s1;
		push.entry.flush = flush_s1;
		push.entry.len   = rd_len;
		push.entry.word  = rd_word << align_sh;
	end

endmodule

[rtl/core/hcbp_queue.sv]
// Short queue of packer work between front and back end.
// Depends on hcbp_pkg.
module hcbp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  hcbp_pkg::push_t     push,
	input  logic                pop,
	output hcbp_pkg::entry_t    head,
	output hcbp_pkg::qstat_t    stat
);

	hcbp_pkg::entry_t                mem_q [hcbp_pkg::QUEUE_DEPTH];
	logic [hcbp_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [hcbp_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [hcbp_pkg::QCNT_W-1:0]     count_q;
	logic                            do_push;
	logic                            do_pop;

	assign stat.count = count_q;
	assign stat.full  = (count_q == hcbp_pkg::QCNT_W'(hcbp_pkg::QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push.valid && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + hcbp_pkg::QCNT_W'(do_push) - hcbp_pkg::QCNT_W'(do_pop);
		end
	end

endmodule

[rtl/core/hcbp_back.sv]
// Back end: bit accumulator, byte assembly and output register.
// Depends on hcbp_pkg.
module hcbp_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hcbp_pkg::entry_t                  head,
	input  logic                              q_empty,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [hcbp_pkg::OUT_DATA_W-1:0]   m_tdata,  // out_byte
	output logic                              m_tlast   // last
);

	logic [hcbp_pkg::BYTE_W-1:0] acc_q;
	logic [2:0]                  pend_q;
	logic                        busy_q;
	logic [hcbp_pkg::CODE_W-1:0] cur_q;
	logic [hcbp_pkg::LEN_W-1:0]  rem_q;
	logic                        m_tvalid_q;
	logic [hcbp_pkg::BYTE_W-1:0] byte_q;
	logic                        last_q;

	logic [hcbp_pkg::CODE_W-1:0] cw;
	logic [hcbp_pkg::LEN_W-1:0]  rem;
	logic                        is_flush;
	logic                        have;
	logic                        adv;
	logic [3:0]                  need;
	logic [hcbp_pkg::LEN_W-1:0]  rem_left;
	logic [hcbp_pkg::BYTE_W-1:0] top8;

	logic                        emit;
	logic [hcbp_pkg::BYTE_W-1:0] emit_byte;
	logic                        emit_last;
	logic                        busy_d;
	logic [hcbp_pkg::CODE_W-1:0] cur_d;
	logic [hcbp_pkg::LEN_W-1:0]  rem_d;
	logic [hcbp_pkg::BYTE_W-1:0] acc_d;
	logic [2:0]                  pend_d;

	assign cw       = busy_q ? cur_q : head.word;
	assign rem      = busy_q ? rem_q : head.len;
	assign is_flush = !busy_q && head.flush;
	assign have     = busy_q || !q_empty;
	assign adv      = !m_tvalid_q || m_tready;
	assign need     = 4'(hcbp_pkg::BYTE_W) - {1'b0, pend_q};
	assign rem_left = rem - hcbp_pkg::LEN_W'(need);
	assign top8     = cw[hcbp_pkg::CODE_W-1:hcbp_pkg::CODE_W-hcbp_pkg::BYTE_W];

	always_comb begin
		pop       = 1'b0;
		emit      = 1'b0;
		emit_byte = '0;
		emit_last = 1'b0;
		busy_d    = busy_q;
		cur_d     = cur_q;
		rem_d     = rem_q;
		acc_d     = acc_q;
		pend_d    = pend_q;
		priority if (!have) begin
			// nothing to do
		end else if (is_flush) begin
			if (pend_q == '0) begin
				pop = 1'b1;
			end else if (adv) begin
				pop       = 1'b1;
				emit      = 1'b1;
				emit_byte = 8'(acc_q << (4'(hcbp_pkg::BYTE_W) - {1'b0, pend_q}));
				emit_last = 1'b1;
				acc_d     = '0;
				pend_d    = '0;
			end
		end else if (rem >= hcbp_pkg::LEN_W'(need)) begin
			// enough bits to close a byte
			if (adv) begin
				pop       = !busy_q;
				emit      = 1'b1;
				emit_byte = 8'(acc_q << need) | (top8 >> pend_q);
				// a leftover shorter than a byte only goes into the accumulator
				emit_last = (rem_left < hcbp_pkg::LEN_W'(hcbp_pkg::BYTE_W));
				busy_d    = (rem_left != '0);
				cur_d     = cw << need;
				rem_d     = rem_left;
				acc_d     = '0;
				pend_d    = '0;
			end
		end else begin
			// tail of the code goes into the accumulator
			pop    = !busy_q;
			busy_d = 1'b0;
			acc_d  = 8'(acc_q << rem[2:0]) | (top8 >> (4'(hcbp_pkg::BYTE_W) - {1'b0, rem[2:0]}));
			pend_d = pend_q + rem[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			pend_q     <= '0;
			busy_q     <= 1'b0;
			rem_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			acc_q  <= acc_d;
			pend_q <= pend_d;
			busy_q <= busy_d;
			rem_q  <= rem_d;
			if (adv) begin
				m_tvalid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		if (adv) begin
			byte_q <= emit_byte;
			last_q <= emit_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = byte_q;
	assign m_tlast  = last_q;

endmodule

[rtl/core/huffman_code_bit_packer.sv]
// Top level of the table-driven Huffman code bit packer.
// Depends on hcbp_pkg, hcbp_front, hcbp_queue, hcbp_back.
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   s_tuser = mode, s_tdata = symbol, code_word, code_length
//  m_*      out  m_tvalid/m_tready   m_tdata = out_byte, m_tlast = last
//
// One input transfer per cycle while s_tready is high; a load finishes in that cycle, an
// encode or flush passes the registered table read in s1 and enters the four-entry queue
// once the queue has room, and its bytes leave through the back end's output register.
// The back end emits one byte per cycle while m_tready allows; a tail of a code shorter
// than a byte moves into the accumulator in a step of its own, emitting no byte. Reset
// clears the accumulator, queue and handshake state only; the code table is not cleared.
// A stalled m_tready holds the output register and fills the queue before s_tready drops.
module huffman_code_bit_packer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [hcbp_pkg::IN_DATA_W-1:0]    s_tdata,  // symbol[7:0], code_word[39:8],
	                                                    // code_length[45:40], zero pad
	input  logic [hcbp_pkg::MODE_W-1:0]       s_tuser,  // mode[1:0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [hcbp_pkg::OUT_DATA_W-1:0]   m_tdata,  // out_byte[7:0]
	output logic                              m_tlast   // last
);

	hcbp_pkg::push_t  push;
	hcbp_pkg::entry_t head;
	hcbp_pkg::qstat_t qstat;
	logic             pop;

	hcbp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (qstat.full),
		.push     (push)
	);

	hcbp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.stat   (qstat)
	);

	hcbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_empty  (qstat.empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= hcbp_pkg::QCNT_W'(hcbp_pkg::QUEUE_DEPTH))
		else $error("queue count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("back end popped an empty queue");

	a_stall_front: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && qstat.full) |-> !s_tready)
		else $error("front took a transfer while stage 1 was blocked");

	a_queue_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && !qstat.full && !pop) |=> (qstat.count == $past(qstat.count) + 1'b1))
		else $error("queue lost a pushed entry");

endmodule

[verif/huffman_code_bit_packer_tb.sv]
// Self-checking testbench for huffman_code_bit_packer: code table loads, encodes and flushes
// checked byte by byte against an in-bench packer model. Depends on hcbp_pkg and the RTL.
`timescale 1ns / 1ps

module huffman_code_bit_packer_tb;
	import hcbp_pkg::*;

	localparam int RANDOM_ITEMS   = 436;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} out_beat_t;

	// Keeps its own copy of the code table and bit accumulator and queues the bytes each
	// accepted input should produce.
	class packer_scoreboard;
		logic [CODE_W-1:0] code_word_tab [SYMBOL_COUNT];
		logic [LEN_W-1:0]  code_len_tab [SYMBOL_COUNT];
		logic [BYTE_W-1:0] acc_bits;
		int                acc_count;
		out_beat_t         expected_bytes[$];
		int                errors;
		int                bytes_checked;

		function new();
			acc_bits      = '0;
			acc_count     = 0;
			errors        = 0;
			bytes_checked = 0;
		endfunction

		function void note_item(mode_t mode, logic [SYM_W-1:0] sym, logic [CODE_W-1:0] word,
				logic [LEN_W-1:0] len);
			out_beat_t beats[$];
			out_beat_t b;
			int        l;
			case (mode)
				MODE_LOAD: begin
					code_word_tab[sym] = word;
					code_len_tab[sym]  = (len > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : len;
				end
				MODE_ENCODE: begin
					l = int'(code_len_tab[sym]);
					// MSB of the code goes in first
					for (int i = l - 1; i >= 0; i--) begin
						acc_bits = {acc_bits[BYTE_W-2:0], code_word_tab[sym][i]};
						acc_count++;
						if (acc_count == BYTE_W) begin
							b.data = acc_bits;
							b.last = 1'b0;
							beats.push_back(b);
							acc_bits  = '0;
							acc_count = 0;
						end
					end
				end
				MODE_FLUSH: begin
					if (acc_count > 0) begin
						b.data = BYTE_W'(acc_bits << (BYTE_W - acc_count));
						b.last = 1'b0;
						beats.push_back(b);
						acc_bits  = '0;
						acc_count = 0;
					end
				end
				default: ;
			endcase
			if (beats.size() > 0)
				beats[beats.size()-1].last = 1'b1;
			foreach (beats[i])
				expected_bytes.push_back(beats[i]);
		endfunction

		function void check_byte(logic [BYTE_W-1:0] data, logic last);
			out_beat_t exp_b;
			bytes_checked++;
			if (expected_bytes.size() == 0) begin
				errors++;
				$display("%0t: unexpected output byte %02h last %0b", $time, data, last);
				return;
			end
			exp_b = expected_bytes.pop_front();
			if (data !== exp_b.data) begin
				errors++;
				$display("%0t: out_byte mismatch: expected %02h, got %02h",
					$time, exp_b.data, data);
			end
			if (last !== exp_b.last) begin
				errors++;
				$display("%0t: last mismatch: expected %0b, got %0b", $time, exp_b.last, last);
			end
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [MODE_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	huffman_code_bit_packer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	packer_scoreboard sb;
	int               src_idle_pct;
	int               dst_idle_pct;
	bit               hold_req;
	bit               hold_done;
	int               hold_left;
	int               idle_cycles;
	int               mode_count [4];
	bit               loaded [SYMBOL_COUNT];
	logic [SYM_W-1:0] loaded_syms[$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Sender: starts and ends on a falling edge.
	task automatic send_item(mode_t mode, logic [SYM_W-1:0] sym, logic [CODE_W-1:0] word,
			logic [LEN_W-1:0] len);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {2'b00, len, word, sym};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_item(mode, sym, word, len);
		mode_count[mode]++;
		@(negedge clk);
	endtask

	task automatic load_code(logic [SYM_W-1:0] sym, logic [CODE_W-1:0] word,
			logic [LEN_W-1:0] len);
		send_item(MODE_LOAD, sym, word, len);
		if (!loaded[sym]) begin
			loaded[sym] = 1'b1;
			loaded_syms.push_back(sym);
		end
	endtask

	// Fields other than the symbol carry noise; the block should ignore them.
	task automatic encode_sym(logic [SYM_W-1:0] sym);
		send_item(MODE_ENCODE, sym, $urandom(), LEN_W'($urandom()));
	endtask

	task automatic flush_bits();
		send_item(MODE_FLUSH, SYM_W'($urandom()), $urandom(), LEN_W'($urandom()));
	endtask

	task automatic random_item();
		int               r;
		int               lr;
		logic [LEN_W-1:0] len;
		r = $urandom_range(99);
		if (loaded_syms.size() == 0 || r < 20) begin
			lr = $urandom_range(99);
			if (lr < 70)
				len = LEN_W'($urandom_range(12, 1));
			else if (lr < 80)
				len = LEN_W'($urandom_range(31, 13));
			else if (lr < 88)
				len = LEN_W'(MAX_CODE_LEN);
			else if (lr < 94)
				len = LEN_W'($urandom_range(63, 33));
			else
				len = '0;
			load_code(SYM_W'($urandom()), $urandom(), len);
		end else if (r < 80) begin
			encode_sym(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
		end else if (r < 92) begin
			flush_bits();
		end else begin
			send_item(MODE_NONE, SYM_W'($urandom()), $urandom(), LEN_W'($urandom()));
		end
	endtask

	// Receiver: random back-pressure, plus one long hold-off when asked for.
	initial begin
		m_tready  = 1'b0;
		hold_done = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (!arst_n) begin
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= dst_idle_pct);
			end
		end
	end

	// Output check and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_byte(m_tdata, m_tlast);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d bytes still expected",
					$time, idle_cycles, sb.pending());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		int src_pct [3];
		int dst_pct [3];
		int per_phase;
		sb           = new();
		src_pct      = '{17, 60, 0};
		dst_pct      = '{60, 17, 0};
		per_phase    = RANDOM_ITEMS / 3;
		idle_cycles  = 0;
		hold_req     = 1'b0;
		src_idle_pct = src_pct[0];
		dst_idle_pct = dst_pct[0];
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = MODE_LOAD;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty flush, ignored mode, extreme codes, saturation, zero length
		send_item(MODE_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
		send_item(MODE_NONE, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
		load_code(8'd0, 32'hFFFF_FFFF, 6'd32);
		load_code(8'd255, 32'h0000_0000, 6'd32);
		load_code(8'd1, 32'hA5A5_A5A5, 6'd63);
		load_code(8'd2, 32'hFFFF_FFF2, 6'd3);
		load_code(8'd3, 32'h1234_5678, 6'd0);
		load_code(8'd4, 32'h0000_0001, 6'd1);
		encode_sym(8'd0);
		encode_sym(8'd255);
		encode_sym(8'd1);
		encode_sym(8'd3);
		encode_sym(8'd2);
		encode_sym(8'd4);
		flush_bits();
		flush_bits();
		repeat (3) encode_sym(8'd2);
		encode_sym(8'd0);
		load_code(8'd128, 32'h8000_0001, 6'd32);
		encode_sym(8'd128);
		flush_bits();
		load_code(8'd5, 32'h0000_007F, 6'd7);
		encode_sym(8'd5);

		for (int p = 0; p < 3; p++) begin
			src_idle_pct = src_pct[p];
			dst_idle_pct = dst_pct[p];
			// last phase: no random idling, but one long receiver stall to fill the block
			if (p == 2)
				hold_req = 1'b1;
			for (int i = 0; i < ((p == 2) ? RANDOM_ITEMS - 2 * per_phase : per_phase); i++)
				random_item();
		end
		flush_bits();
		s_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d loads, %0d encodes, %0d flushes, %0d ignored items;",
			mode_count[MODE_LOAD], mode_count[MODE_ENCODE], mode_count[MODE_FLUSH],
			mode_count[MODE_NONE]);
		$display("%0d output bytes checked over three back-pressure phases, %0d errors.",
			sb.bytes_checked, sb.errors);
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
